// File: sv/epco_pkg.sv
`timescale 1ns / 1ps
package epco_pkg;

  localparam int LIN_W = 23;
  localparam int COORD_W = 12;
  localparam int PROD_W = 29;
  localparam int MAP_W = 18;

  localparam logic signed [COORD_W-1:0] CENTRE_X = 12'sd640;
  localparam logic signed [COORD_W-1:0] CENTRE_Y = 12'sd360;
  localparam logic signed [MAP_W-1:0] OFFSET_X = 18'sd1920;
  localparam logic signed [MAP_W-1:0] OFFSET_Y = 18'sd1080;

  localparam logic [1:0] REG_MAX_COUNT = 2'd0;
  localparam logic [1:0] REG_TARGET_WIDTH = 2'd1;
  localparam logic [1:0] REG_TARGET_HEIGHT = 2'd2;
  localparam logic [1:0] REG_SCALE = 2'd3;

  localparam logic [15:0] MAX_COUNT_RST = 16'd10;
  localparam logic [11:0] TARGET_WIDTH_RST = 12'd1280;
  localparam logic [11:0] TARGET_HEIGHT_RST = 12'd720;
  localparam logic [15:0] SCALE_RST = 16'd13729;

  localparam logic [1:0] DOM_NONE = 2'd0;
  localparam logic [1:0] DOM_POS = 2'd1;
  localparam logic [1:0] DOM_NEG = 2'd2;

  typedef struct packed {
    logic signed [12:0] tx;
    logic signed [12:0] ty;
    logic in_target;
  } map_res_t;

endpackage

// File: sv/event_polarity_count_overlay.sv
`timescale 1ns / 1ps
// channel | direction | handshake           | beat
// input   | in        | in_valid / in_ready | operation, pixel_x, pixel_y, polarity
// output  | out       | out_valid/out_ready | target_x, target_y, in_range, dominant, intensity
// config  | in        | APB, pready high    | max_count, target_width, target_height, scale_q12
// A record beat passes accept, counter-RAM read, then write-back on the RAM's one port.
// A read beat does the same read, then the divider, and waits there until the output register is free.
// After reset a clearing pass writes zero to each of the SENSOR_WIDTH*SENSOR_HEIGHT RAM rows
// (921600 by default), one per cycle; in_ready stays low meanwhile.
// A read result waits in the output register; the next beat can be taken meanwhile.
module event_polarity_count_overlay #(
  parameter int SENSOR_WIDTH = 1280,
  parameter int SENSOR_HEIGHT = 720,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [10:0]        pixel_x,
  input  logic [9:0]         pixel_y,
  input  logic               polarity,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [12:0] target_x,
  output logic signed [12:0] target_y,
  output logic               in_range,
  output logic [1:0]         dominant,
  output logic [7:0]         intensity
);
  import epco_pkg::*;

  localparam int PIXELS = SENSOR_WIDTH * SENSOR_HEIGHT;
  localparam int AW = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int CB = COUNT_BITS;
  localparam logic [15:0] COUNT_MAX = 16'((1 << COUNT_BITS) - 1);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_DIV    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  logic [15:0] max_count;
  logic [11:0] target_width;
  logic [11:0] target_height;
  logic [15:0] scale_q12;

  logic          op_r;
  logic [10:0]   x_r;
  logic [9:0]    y_r;
  logic          pol_r;
  logic [LIN_W-1:0] lin;
  logic          in_sensor;
  logic          in_sensor_r;
  logic [AW-1:0] clr_addr;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [2*CB-1:0] ram_wdata;
  logic [2*CB-1:0] ram_rdata;

  logic [CB-1:0] pos;
  logic [CB-1:0] neg;
  logic [CB-1:0] cur;
  logic [CB-1:0] diff;
  logic [1:0]    dom;
  logic [1:0]    dom_r;
  logic [15:0]   limit;
  logic          div_start;
  logic          div_done;
  logic [7:0]    div_q;
  map_res_t      map_res;
  logic          out_free;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count <= MAX_COUNT_RST;
      target_width <= TARGET_WIDTH_RST;
      target_height <= TARGET_HEIGHT_RST;
      scale_q12 <= SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_MAX_COUNT:     max_count <= pwdata[15:0];
        REG_TARGET_WIDTH:  target_width <= pwdata[11:0];
        REG_TARGET_HEIGHT: target_height <= pwdata[11:0];
        REG_SCALE:         scale_q12 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MAX_COUNT:     prdata = {16'b0, max_count};
      REG_TARGET_WIDTH:  prdata = {20'b0, target_width};
      REG_TARGET_HEIGHT: prdata = {20'b0, target_height};
      REG_SCALE:         prdata = {16'b0, scale_q12};
      default:           prdata = 32'b0;
    endcase
  end

  assign lin = LIN_W'(y_r) * LIN_W'(SENSOR_WIDTH) + LIN_W'(x_r);
  assign in_sensor = lin < LIN_W'(PIXELS);

  assign pos = in_sensor_r ? ram_rdata[2*CB-1:CB] : '0;
  assign neg = in_sensor_r ? ram_rdata[CB-1:0] : '0;
  assign cur = pol_r ? pos : neg;
  assign limit = (max_count < COUNT_MAX) ? max_count : COUNT_MAX;

  always_comb begin
    dom = DOM_NONE;
    diff = '0;
    if (pos != '0 && pos >= neg) begin
      dom = DOM_POS;
      diff = pos - neg;
    end else if (neg != '0 && neg > pos) begin
      dom = DOM_NEG;
      diff = neg - pos;
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_addr = lin[AW-1:0];
    ram_wdata = pol_r ? {cur + CB'(1), neg} : {pos, cur + CB'(1)};
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
      ram_addr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_MODIFY && !op_r && in_sensor_r && 16'(cur) < limit) begin
      ram_we = 1'b1;
    end
  end

  epco_ram #(
    .WIDTH(2 * CB),
    .DEPTH(PIXELS)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .addr(ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign div_start = (state == S_MODIFY) && op_r;

  epco_div #(
    .COUNT_BITS(CB)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .diff(diff),
    .max_count(max_count),
    .done(div_done),
    .intensity(div_q)
  );

  epco_map u_map (
    .clk(clk),
    .load(div_start),
    .x(x_r),
    .y(y_r),
    .scale(scale_q12),
    .target_w(target_width),
    .target_h(target_height),
    .res(map_res)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_addr == AW'(PIXELS - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ:   state_next = S_MODIFY;
      S_MODIFY: state_next = op_r ? S_DIV : S_IDLE;
      S_DIV:    if (div_done && out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_DIV && div_done && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= operation;
      x_r <= pixel_x;
      y_r <= pixel_y;
      pol_r <= polarity;
    end
    if (state == S_READ) begin
      in_sensor_r <= in_sensor;
    end
    if (state == S_MODIFY) begin
      dom_r <= dom;
    end
    if (state == S_DIV && div_done && out_free) begin
      target_x <= map_res.tx;
      target_y <= map_res.ty;
      in_range <= map_res.in_target && in_sensor_r;
      dominant <= dom_r;
      intensity <= div_q;
    end
  end

endmodule

// File: sv/epco_ram.sv
`timescale 1ns / 1ps
module epco_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/epco_div.sv
`timescale 1ns / 1ps
module epco_div #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] diff,
  input  logic [15:0]           max_count,
  output logic                  done,
  output logic [7:0]            intensity
);

  localparam int NW = COUNT_BITS + 8;

  logic [NW-1:0] num;
  logic [16:0]   rem;
  logic [7:0]    lo;
  logic [2:0]    cnt;
  logic          busy;
  logic [16:0]   trial;
  logic          fits;

  assign num = NW'(diff) * NW'(255);
  assign trial = {rem[15:0], lo[7]};
  assign fits = trial >= {1'b0, max_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      busy <= 1'b0;
    end else if (start) begin
      cnt <= 3'd0;
      if (diff == '0) begin
        intensity <= 8'd0;
        done <= 1'b1;
        busy <= 1'b0;
      end else if (24'(num) >= {max_count, 8'h00}) begin
        intensity <= 8'hff;
        done <= 1'b1;
        busy <= 1'b0;
      end else begin
        rem <= 17'(num >> 8);
        lo <= num[7:0];
        intensity <= 8'd0;
        done <= 1'b0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      rem <= fits ? trial - {1'b0, max_count} : trial;
      lo <= {lo[6:0], 1'b0};
      intensity <= {intensity[6:0], fits};
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: sv/epco_map.sv
`timescale 1ns / 1ps
module epco_map (
  input  logic                clk,
  input  logic                load,
  input  logic [10:0]         x,
  input  logic [9:0]          y,
  input  logic [15:0]         scale,
  input  logic [11:0]         target_w,
  input  logic [11:0]         target_h,
  output epco_pkg::map_res_t  res
);
  import epco_pkg::*;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [MAP_W-1:0]  mx;
  logic signed [MAP_W-1:0]  my;

  function automatic logic signed [MAP_W-1:0] fold(input logic signed [PROD_W-1:0] p,
                                                    input logic signed [MAP_W-1:0] off);
    logic [PROD_W-1:0] mag;
    logic [MAP_W-1:0]  whole;
    mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
    whole = MAP_W'(mag >> 12);
    return (p[PROD_W-1] ? -$signed(whole) : $signed(whole)) + off;
  endfunction

  function automatic logic signed [12:0] sat13(input logic signed [MAP_W-1:0] v);
    if (v < -18'sd4096) begin
      return -13'sd4096;
    end else if (v > 18'sd4095) begin
      return 13'sd4095;
    end else begin
      return 13'(v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (load) begin
      prod_x <= ($signed({1'b0, x}) - CENTRE_X) * $signed({1'b0, scale});
      prod_y <= ($signed({2'b00, y}) - CENTRE_Y) * $signed({1'b0, scale});
    end
  end

  assign mx = fold(prod_x, OFFSET_X);
  assign my = fold(prod_y, OFFSET_Y);

  always_comb begin
    res.tx = sat13(mx);
    res.ty = sat13(my);
    res.in_target = !mx[MAP_W-1] && !my[MAP_W-1] &&
                    (mx < $signed({6'b0, target_w})) && (my < $signed({6'b0, target_h}));
  end

endmodule

// File: tb/tb_event_polarity_count_overlay.sv
`timescale 1ns / 1ps
module tb_event_polarity_count_overlay;
  import epco_pkg::*;

  localparam int SENSOR_W = 1280;
  localparam int SENSOR_H = 720;
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ = 1'b1;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 180;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 3000000;

  typedef struct packed {
    logic signed [12:0] target_x;
    logic signed [12:0] target_y;
    logic               in_range;
    logic [1:0]         dominant;
    logic [7:0]         intensity;
  } overlay_t;

  class overlay_scoreboard;
    bit [15:0] pixel_counts [int unsigned];
    logic [15:0] max_count;
    logic [11:0] target_w;
    logic [11:0] target_h;
    logic [15:0] scale;
    overlay_t overlay_q [$];
    int unsigned mismatches;

    function new();
      max_count = MAX_COUNT_RST;
      target_w = TARGET_WIDTH_RST;
      target_h = TARGET_HEIGHT_RST;
      scale = SCALE_RST;
      mismatches = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
    endfunction

    function int pending();
      return overlay_q.size();
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] word);
      case (idx)
        REG_MAX_COUNT: max_count = word[15:0];
        REG_TARGET_WIDTH: target_w = word[11:0];
        REG_TARGET_HEIGHT: target_h = word[11:0];
        REG_SCALE: scale = word[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_MAX_COUNT: return {16'd0, max_count};
        REG_TARGET_WIDTH: return {20'd0, target_w};
        REG_TARGET_HEIGHT: return {20'd0, target_h};
        default: return {16'd0, scale};
      endcase
    endfunction

    // (coord - centre) * scale / 4096, truncated toward zero, plus offset
    function longint map_coord(int unsigned coord, longint centre, longint offset);
      longint prod;
      longint mag;
      prod = (longint'(coord) - centre) * longint'(scale);
      mag = (prod < 0) ? -prod : prod;
      mag = mag >> 12;
      return ((prod < 0) ? -mag : mag) + offset;
    endfunction

    function logic signed [12:0] sat13(longint v);
      if (v < -4096) v = -4096;
      if (v > 4095) v = 4095;
      return v[12:0];
    endfunction

    function int unsigned count_of(int unsigned key);
      return pixel_counts.exists(key) ? pixel_counts[key] : 0;
    endfunction

    function void take_pixel_op(logic op, logic [10:0] x, logic [9:0] y, logic pol);
      int unsigned addr;
      int unsigned key;
      int unsigned c;
      bit on_sensor;
      longint tx;
      longint ty;
      longint pos;
      longint neg;
      longint diff;
      longint q;
      overlay_t ov;
      addr = y * SENSOR_W + x;
      on_sensor = addr < SENSOR_W * SENSOR_H;
      if (op == OP_RECORD) begin
        if (on_sensor) begin
          key = addr * 2 + pol;
          c = count_of(key);
          if (c < max_count) pixel_counts[key] = 16'(c + 1);
        end
        return;
      end
      tx = map_coord(x, longint'(CENTRE_X), longint'(OFFSET_X));
      ty = map_coord(y, longint'(CENTRE_Y), longint'(OFFSET_Y));
      neg = on_sensor ? count_of(addr * 2) : 0;
      pos = on_sensor ? count_of(addr * 2 + 1) : 0;
      ov.dominant = DOM_NONE;
      diff = 0;
      if (pos > 0 && pos >= neg) begin
        ov.dominant = DOM_POS;
        diff = pos - neg;
      end else if (neg > 0 && neg > pos) begin
        ov.dominant = DOM_NEG;
        diff = neg - pos;
      end
      ov.intensity = 8'd0;
      if (ov.dominant != DOM_NONE) begin
        if (max_count == 0) begin
          ov.intensity = (diff != 0) ? 8'd255 : 8'd0;
        end else begin
          q = (255 * diff) / longint'(max_count);
          ov.intensity = (q > 255) ? 8'd255 : q[7:0];
        end
      end
      ov.in_range = on_sensor && tx >= 0 && ty >= 0 &&
                    tx < longint'(target_w) && ty < longint'(target_h);
      ov.target_x = sat13(tx);
      ov.target_y = sat13(ty);
      overlay_q = {overlay_q, ov};
    endfunction

    function void check_overlay(overlay_t got);
      overlay_t want;
      if (overlay_q.size() == 0) begin
        flag($sformatf("unexpected beat tx=%0d ty=%0d in=%0d dom=%0d int=%0d",
                       got.target_x, got.target_y, got.in_range, got.dominant,
                       got.intensity));
        return;
      end
      want = overlay_q.pop_front();
      if (got !== want)
        flag($sformatf({"exp tx=%0d ty=%0d in=%0d dom=%0d int=%0d, ",
                        "got tx=%0d ty=%0d in=%0d dom=%0d int=%0d"},
                       want.target_x, want.target_y, want.in_range, want.dominant,
                       want.intensity, got.target_x, got.target_y, got.in_range,
                       got.dominant, got.intensity));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic operation = 1'b0;
  logic [10:0] pixel_x = '0;
  logic [9:0] pixel_y = '0;
  logic polarity = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [12:0] target_x;
  logic signed [12:0] target_y;
  logic in_range;
  logic [1:0] dominant;
  logic [7:0] intensity;

  bit quiet = 1'b0;
  int unsigned stall_cycles = 0;
  overlay_scoreboard sb;

  int unsigned ph_max [N_PHASES] = '{3, 65535, 2, 0, 1, 0};
  int unsigned ph_tw [N_PHASES] = '{1280, 4095, 1, 0, 2000, 0};
  int unsigned ph_th [N_PHASES] = '{720, 4095, 1, 0, 1500, 0};
  int unsigned ph_scale [N_PHASES] = '{13729, 65535, 0, 4096, 8192, 0};

  event_polarity_count_overlay #(
    .SENSOR_WIDTH(SENSOR_W),
    .SENSOR_HEIGHT(SENSOR_H),
    .COUNT_BITS(16)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .operation(operation),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .polarity(polarity),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .target_x(target_x),
    .target_y(target_y),
    .in_range(in_range),
    .dominant(dominant),
    .intensity(intensity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_pixel_op(operation, pixel_x, pixel_y, polarity);
      if (out_valid && out_ready)
        sb.check_overlay('{target_x, target_y, in_range, dominant, intensity});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("event_polarity_count_overlay test failed");
          $finish;
        end
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic issue_pixel_op(input logic op, input logic [10:0] x, input logic [9:0] y,
                                input logic pol);
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    pixel_x <= x;
    pixel_y <= y;
    polarity <= pol;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] word;
    logic [31:0] readback;
    word = $urandom();
    if (idx == REG_TARGET_WIDTH || idx == REG_TARGET_HEIGHT) word[11:0] = val[11:0];
    else word[15:0] = val;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    sb.set_reg(idx, word);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== sb.reg_value(idx))
      sb.flag($sformatf("reg %0d readback exp %0h got %0h", idx, sb.reg_value(idx),
                        readback));
  endtask

  task automatic run_directed();
    issue_pixel_op(OP_READ, 11'd0, 10'd0, 1'b0);
    issue_pixel_op(OP_RECORD, 11'd0, 10'd0, 1'b1);
    issue_pixel_op(OP_READ, 11'd0, 10'd0, 1'b0);
    issue_pixel_op(OP_RECORD, 11'd0, 10'd0, 1'b0);
    issue_pixel_op(OP_RECORD, 11'd0, 10'd0, 1'b0);
    issue_pixel_op(OP_READ, 11'd0, 10'd0, 1'b0);
    // tie goes to positive
    issue_pixel_op(OP_RECORD, 11'd0, 10'd0, 1'b1);
    issue_pixel_op(OP_READ, 11'd0, 10'd0, 1'b1);
    // off sensor: record dropped, read still mapped and saturated
    issue_pixel_op(OP_RECORD, 11'd2047, 10'd1023, 1'b1);
    issue_pixel_op(OP_READ, 11'd2047, 10'd1023, 1'b1);
    issue_pixel_op(OP_RECORD, 11'd1279, 10'd719, 1'b0);
    issue_pixel_op(OP_READ, 11'd1279, 10'd719, 1'b0);
    issue_pixel_op(OP_READ, 11'd1280, 10'd719, 1'b0);
    // column past the width aliases into the next row
    issue_pixel_op(OP_RECORD, 11'd1300, 10'd100, 1'b1);
    issue_pixel_op(OP_READ, 11'd20, 10'd101, 1'b0);
    issue_pixel_op(OP_READ, 11'd1300, 10'd100, 1'b0);
    issue_pixel_op(OP_RECORD, 11'd2047, 10'd0, 1'b0);
    issue_pixel_op(OP_READ, 11'd767, 10'd1, 1'b1);
    issue_pixel_op(OP_READ, 11'd640, 10'd360, 1'b0);
    issue_pixel_op(OP_READ, 11'd0, 10'd1023, 1'b1);
  endtask

  task automatic run_random(input int n);
    logic [10:0] hx [7];
    logic [9:0] hy [7];
    int k;
    int pick;
    int sel;
    for (k = 0; k < 4; k++) begin
      hx[k] = 11'($urandom_range(0, SENSOR_W - 1));
      hy[k] = 10'($urandom_range(0, SENSOR_H - 1));
    end
    hx[4] = 11'($urandom_range(SENSOR_W, 2047));
    hy[4] = 10'($urandom_range(0, SENSOR_H - 3));
    hx[5] = hx[4] - 11'(SENSOR_W);
    hy[5] = hy[4] + 10'd1;
    hx[6] = 11'($urandom_range(0, 2047));
    hy[6] = 10'($urandom_range(SENSOR_H, 1023));
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      sel = $urandom_range(0, 6);
      if (pick < 55) begin
        issue_pixel_op(OP_RECORD, hx[sel], hy[sel],
                       ($urandom_range(0, 3) != 0) ? sel[0] : ~sel[0]);
      end else if (pick < 80) begin
        issue_pixel_op(OP_READ, hx[sel], hy[sel], 1'($urandom_range(0, 1)));
      end else begin
        issue_pixel_op((pick < 90) ? OP_READ : OP_RECORD, 11'($urandom_range(0, 2047)),
                       10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    run_directed();
    for (int p = 0; p < N_PHASES; p++) begin
      quiet = 1'b0;
      settle();
      if (p == N_PHASES - 1) begin
        ph_max[p] = $urandom_range(1, 12);
        ph_tw[p] = $urandom_range(0, 4095);
        ph_th[p] = $urandom_range(0, 4095);
        ph_scale[p] = $urandom_range(0, 65535);
      end
      program_reg(REG_MAX_COUNT, 16'(ph_max[p]));
      program_reg(REG_TARGET_WIDTH, 16'(ph_tw[p]));
      program_reg(REG_TARGET_HEIGHT, 16'(ph_th[p]));
      program_reg(REG_SCALE, 16'(ph_scale[p]));
      quiet = (p == 0);
      run_random(PHASE_ITEMS);
    end
    quiet = 1'b0;
    settle();
    if (sb.mismatches == 0) begin
      $display("event_polarity_count_overlay test passed");
    end else begin
      $display("event_polarity_count_overlay test failed");
    end
    $finish;
  end

endmodule
